// ===== hw/rtl/tper_pkg.sv =====
// Package with the constants, widths and types shared by the pin event replay block.
package tper_pkg;

  // Table and pin sizes.
  localparam int EVENT_CAPACITY = 512;
  localparam int PIN_COUNT      = 64;

  // Widths derived from the sizes.
  localparam int IDX_W = (EVENT_CAPACITY > 1) ? $clog2(EVENT_CAPACITY) : 1;
  localparam int CNT_W = $clog2(EVENT_CAPACITY + 1);
  localparam int PIN_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

  // Fixed field widths.
  localparam int TIME_W = 64;
  localparam int PINF_W = 8;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  // One stored event.
  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    logic [PINF_W-1:0] ev_pin;
    logic              ev_level;
  } event_t;

  // True when a physical pin has a slot in the pin tables.
  function automatic logic pin_in_range(input logic [PINF_W-1:0] pin);
    pin_in_range = ((PINF_W + 1)'(pin) < (PINF_W + 1)'(PIN_COUNT));
  endfunction

endpackage

// ===== hw/rtl/tper_if.sv =====
// Valid/ready channel interfaces for the request and result beats.
interface tper_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [tper_pkg::TIME_W-1:0] event_time;
  logic [tper_pkg::PINF_W-1:0] event_pin;
  logic                        event_level;
  logic [tper_pkg::PINF_W-1:0] query_pin;
  logic [tper_pkg::TIME_W-1:0] now_time;

  modport source (output valid, req_type, event_time, event_pin, event_level, query_pin,
                  now_time, input ready);
  modport sink (input valid, req_type, event_time, event_pin, event_level, query_pin,
                now_time, output ready);
endinterface

interface tper_out_if;
  logic valid;
  logic ready;
  logic pin_known;
  logic pin_level;

  modport source (output valid, pin_known, pin_level, input ready);
  modport sink (input valid, pin_known, pin_level, output ready);
endinterface

// ===== hw/rtl/timed_pin_event_replay_top.sv =====
// Top level of the timed pin event replay block: event table, replay sequencer and result port.
//
// The block keeps a time-ordered table of pin events in a single-port-write, registered-read
// memory and works on one request beat at a time. A begin-load beat is handled without leaving
// the idle state. An add-event beat walks down the table from its end, one read and compare
// (with a write moving the entry up) per stored event with a later time, then writes the new
// event; one that lands at the front saves the last compare, and the first event into an empty
// table is written with no read or compare. A query beat forms the elapsed time, replays each
// due event with one read and compare, then reads the pin level and registers the result; the
// one shared 64-bit comparator and the table's read port are used once per step. A finished
// result sits in an output register, so the next beat can be taken while it waits; a further
// query result waits until that register is free. No clearing pass is needed after reset.
module timed_pin_event_replay_top (
  input logic         clk,
  input logic         rst_n,
  tper_in_if.sink     in_ch,
  tper_out_if.source  out_ch
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_WR,
    S_Q_SUB,
    S_Q_RD,
    S_Q_CMP,
    S_Q_PIN,
    S_Q_OUT,
    S_RESP
  } state_t;

  state_t                         state_r, state_nxt;
  logic [tper_pkg::CNT_W-1:0]     total_r, total_nxt;
  logic [tper_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic [tper_pkg::CNT_W-1:0]     pos_r, pos_nxt;
  logic [tper_pkg::TIME_W-1:0]    start_r, start_nxt;
  logic [tper_pkg::TIME_W-1:0]    elapsed_r, elapsed_nxt;
  logic                           loaded_r, loaded_nxt;
  logic [tper_pkg::PIN_COUNT-1:0] known_r, known_nxt;
  tper_pkg::event_t               new_ev_r, new_ev_nxt;
  logic [tper_pkg::PINF_W-1:0]    qpin_r, qpin_nxt;
  logic [tper_pkg::TIME_W-1:0]    qnow_r, qnow_nxt;
  logic                           res_known_r, res_known_nxt;
  logic                           res_level_r, res_level_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_known_r, out_known_nxt;
  logic                           out_level_r, out_level_nxt;

  // Event table and pin level memories.
  tper_pkg::event_t ev_mem [tper_pkg::EVENT_CAPACITY];
  tper_pkg::event_t rd_ev_r;
  logic             ev_we;
  logic [tper_pkg::IDX_W-1:0] ev_waddr, ev_raddr;
  tper_pkg::event_t ev_wdata;

  logic lvl_mem [tper_pkg::PIN_COUNT];
  logic lvl_rd_r;
  logic lvl_we;
  logic [tper_pkg::PIN_W-1:0] lvl_waddr, lvl_raddr;
  logic lvl_wdata;

  logic                       in_fire;
  logic                       cmp_lt;
  logic [tper_pkg::TIME_W-1:0] cmp_lhs;
  logic [tper_pkg::CNT_W-1:0] pos_m1;
  logic                       ev_pin_ok;
  logic                       q_pin_ok;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign in_fire          = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.pin_known = out_known_r;
  assign out_ch.pin_level = out_level_r;

  // The shared comparator: new time against a stored time while inserting, elapsed time
  // against a stored time while replaying.
  assign cmp_lhs   = (state_r == S_INS_CMP) ? new_ev_r.ev_time : elapsed_r;
  assign cmp_lt    = (cmp_lhs < rd_ev_r.ev_time);
  assign pos_m1    = pos_r - 1'b1;
  assign ev_pin_ok = tper_pkg::pin_in_range(rd_ev_r.ev_pin);
  assign q_pin_ok  = tper_pkg::pin_in_range(qpin_r);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    start_nxt     = start_r;
    elapsed_nxt   = elapsed_r;
    loaded_nxt    = loaded_r;
    known_nxt     = known_r;
    new_ev_nxt    = new_ev_r;
    qpin_nxt      = qpin_r;
    qnow_nxt      = qnow_r;
    res_known_nxt = res_known_r;
    res_level_nxt = res_level_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_known_nxt = out_known_r;
    out_level_nxt = out_level_r;
    ev_we         = 1'b0;
    ev_waddr      = pos_r[tper_pkg::IDX_W-1:0];
    ev_wdata      = new_ev_r;
    ev_raddr      = idx_r[tper_pkg::IDX_W-1:0];
    lvl_we        = 1'b0;
    lvl_waddr     = rd_ev_r.ev_pin[tper_pkg::PIN_W-1:0];
    lvl_wdata     = rd_ev_r.ev_level;
    lvl_raddr     = qpin_r[tper_pkg::PIN_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          new_ev_nxt.ev_time  = in_ch.event_time;
          new_ev_nxt.ev_pin   = in_ch.event_pin;
          new_ev_nxt.ev_level = in_ch.event_level;
          qpin_nxt            = in_ch.query_pin;
          qnow_nxt            = in_ch.now_time;
          case (tper_pkg::req_t'(in_ch.req_type))
            tper_pkg::REQ_LOAD: begin
              total_nxt  = '0;
              idx_nxt    = '0;
              start_nxt  = '0;
              known_nxt  = '0;
              loaded_nxt = 1'b1;
            end
            tper_pkg::REQ_ADD: begin
              // A full table drops the event.
              if (total_r < tper_pkg::CNT_W'(tper_pkg::EVENT_CAPACITY)) begin
                pos_nxt   = total_r;
                state_nxt = (total_r == '0) ? S_INS_WR : S_INS_RD;
              end
            end
            tper_pkg::REQ_QUERY: begin
              if (!loaded_r) begin
                res_known_nxt = 1'b0;
                res_level_nxt = 1'b0;
                state_nxt     = S_RESP;
              end else begin
                if (start_r == '0) begin
                  start_nxt = in_ch.now_time;
                end
                state_nxt = S_Q_SUB;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Insertion walks down from the end of the table, moving later events up by one.
      S_INS_RD: begin
        ev_raddr  = pos_m1[tper_pkg::IDX_W-1:0];
        state_nxt = S_INS_CMP;
      end

      S_INS_CMP: begin
        if (cmp_lt) begin
          ev_we     = 1'b1;
          ev_wdata  = rd_ev_r;
          pos_nxt   = pos_m1;
          state_nxt = (pos_m1 == '0) ? S_INS_WR : S_INS_RD;
        end else begin
          state_nxt = S_INS_WR;
        end
      end

      S_INS_WR: begin
        ev_we     = 1'b1;
        total_nxt = total_r + 1'b1;
        if (pos_r < idx_r) begin
          idx_nxt = idx_r + 1'b1;
        end
        state_nxt = S_IDLE;
      end

      S_Q_SUB: begin
        elapsed_nxt = qnow_r - start_r;
        state_nxt   = S_Q_RD;
      end

      // Replay applies pending events one at a time while they are due.
      S_Q_RD: begin
        state_nxt = (idx_r < total_r) ? S_Q_CMP : S_Q_PIN;
      end

      S_Q_CMP: begin
        if (!cmp_lt) begin
          if (ev_pin_ok) begin
            lvl_we = 1'b1;
            known_nxt[rd_ev_r.ev_pin[tper_pkg::PIN_W-1:0]] = 1'b1;
          end
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_Q_RD;
        end else begin
          state_nxt = S_Q_PIN;
        end
      end

      S_Q_PIN: begin
        state_nxt = S_Q_OUT;
      end

      S_Q_OUT: begin
        res_known_nxt = q_pin_ok && known_r[qpin_r[tper_pkg::PIN_W-1:0]];
        res_level_nxt = res_known_nxt && lvl_rd_r;
        state_nxt     = S_RESP;
      end

      // The result moves to the output register once it is free.
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_known_nxt = res_known_r;
          out_level_nxt = res_level_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      idx_r       <= '0;
      start_r     <= '0;
      loaded_r    <= 1'b0;
      known_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      idx_r       <= idx_nxt;
      start_r     <= start_nxt;
      loaded_r    <= loaded_nxt;
      known_r     <= known_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r       <= pos_nxt;
    elapsed_r   <= elapsed_nxt;
    new_ev_r    <= new_ev_nxt;
    qpin_r      <= qpin_nxt;
    qnow_r      <= qnow_nxt;
    res_known_r <= res_known_nxt;
    res_level_r <= res_level_nxt;
    out_known_r <= out_known_nxt;
    out_level_r <= out_level_nxt;
  end

  // Event table.
  always_ff @(posedge clk) begin
    if (ev_we) begin
      ev_mem[ev_waddr] <= ev_wdata;
    end
    rd_ev_r <= ev_mem[ev_raddr];
  end

  // Pin level table; its read value is only used where the known mark is set.
  always_ff @(posedge clk) begin
    if (lvl_we) begin
      lvl_mem[lvl_waddr] <= lvl_wdata;
    end
    lvl_rd_r <= lvl_mem[lvl_raddr];
  end

endmodule

// ===== hw/rtl/tper_checker.sv =====
// Port checker for the pin event replay block and its bind to the top level.
module tper_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_known,
  input logic out_level
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_known) && $stable(out_level))
    else $error("result beat changed while stalled");

  // An unknown pin always reports level zero.
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_known |-> !out_level)
    else $error("unknown pin reported a nonzero level");

  // A new result appears only after the block was busy on a query.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a busy query phase");

endmodule

bind timed_pin_event_replay_top tper_checker u_tper_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_known (out_ch.pin_known),
  .out_level (out_ch.pin_level)
);
